[rtl/core/kwmpq_pkg.sv]
// ----------------------------------------------------------------------------
// kwmpq_pkg
// Types, codes and the entry ordering shared by the k-way merge queue.
// ----------------------------------------------------------------------------
package kwmpq_pkg;

  localparam int unsigned NUM_CELLS  = 64;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned RUN_W      = 6;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-3:0] REG_KEY_SIGNED = '0;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_CELLS);

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_REPLACE = 2'd1,
    CMD_REMOVE  = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [RUN_W-1:0] run;
    logic [KEY_W-1:0] key;
  } in_beat_t;

  typedef struct packed {
    logic             popped_valid;
    logic [KEY_W-1:0] popped_key;
    logic [RUN_W-1:0] popped_run;
    logic             top_valid;
    logic [KEY_W-1:0] top_key;
    logic [RUN_W-1:0] top_run;
    logic [CNT_W-1:0] entry_count;
    logic [1:0]       status;
  } out_beat_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [RUN_W-1:0] run;
  } entry_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic   en;
    cmd_t   cmd;
    logic   key_signed;
    entry_t ent;
  } row_ctl_t;

  // strict order: key (signed or unsigned), then lower run first
  function automatic logic orders_before(entry_t a, entry_t b, logic sgn);
    logic [KEY_W+RUN_W-1:0] va;
    logic [KEY_W+RUN_W-1:0] vb;
    va = {a.key[KEY_W-1] ^ sgn, a.key[KEY_W-2:0], a.run};
    vb = {b.key[KEY_W-1] ^ sgn, b.key[KEY_W-2:0], b.run};
    return va < vb;
  endfunction

endpackage

[rtl/core/kwmpq_cell.sv]
// ----------------------------------------------------------------------------
// kwmpq_cell
// One slot of the sorted row: keeps, takes the new entry, takes a neighbor, or clears.
// ----------------------------------------------------------------------------
module kwmpq_cell
  import kwmpq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  row_ctl_t ctl,
  input  logic     head,
  input  entry_t   left_ent,
  input  logic     left_valid,
  input  logic     left_ahead,
  input  entry_t   right_ent,
  input  logic     right_valid,
  input  logic     right_ahead,
  output entry_t   ent,
  output logic     valid,
  output logic     ahead,
  output entry_t   ent_nxt
);

  entry_t ent_r;
  logic   valid_r;
  logic   valid_nxt;

  assign ent   = ent_r;
  assign valid = valid_r;
  // this entry stays ahead of the new one
  assign ahead = valid_r && !orders_before(ctl.ent, ent_r, ctl.key_signed);

  always_comb begin
    ent_nxt   = ent_r;
    valid_nxt = valid_r;
    if (ctl.en) begin
      case (ctl.cmd)
        CMD_INSERT: begin
          if (!ahead) begin
            if (left_ahead) begin
              ent_nxt   = ctl.ent;
              valid_nxt = 1'b1;
            end else begin
              ent_nxt   = left_ent;
              valid_nxt = left_valid;
            end
          end
        end
        CMD_REPLACE: begin
          if (right_ahead) begin
            ent_nxt = right_ent;
          end else if (head || ahead) begin
            ent_nxt = ctl.ent;
          end
        end
        CMD_REMOVE: begin
          ent_nxt   = right_ent;
          valid_nxt = right_valid;
        end
        default: begin
          valid_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

[rtl/core/kwmpq_row.sv]
// ----------------------------------------------------------------------------
// kwmpq_row
// Chain of cells holding the live entries in ascending order, minimum first.
// ----------------------------------------------------------------------------
module kwmpq_row
  import kwmpq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  row_ctl_t ctl,
  output entry_t   head_ent,
  output entry_t   head_ent_nxt
);

  entry_t ent   [NUM_CELLS];
  entry_t nxt   [NUM_CELLS];
  logic   valid [NUM_CELLS];
  logic   ahead [NUM_CELLS];

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    entry_t left_ent;
    logic   left_valid;
    logic   left_ahead;
    entry_t right_ent;
    logic   right_valid;
    logic   right_ahead;

    if (i == 0) begin : g_first
      assign left_ent   = '0;
      assign left_valid = 1'b1;
      assign left_ahead = 1'b1;
    end else begin : g_mid_l
      assign left_ent   = ent[i-1];
      assign left_valid = valid[i-1];
      assign left_ahead = ahead[i-1];
    end

    if (i == NUM_CELLS - 1) begin : g_last
      assign right_ent   = '0;
      assign right_valid = 1'b0;
      assign right_ahead = 1'b0;
    end else begin : g_mid_r
      assign right_ent   = ent[i+1];
      assign right_valid = valid[i+1];
      assign right_ahead = ahead[i+1];
    end

    kwmpq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .head        (i == 0),
      .left_ent    (left_ent),
      .left_valid  (left_valid),
      .left_ahead  (left_ahead),
      .right_ent   (right_ent),
      .right_valid (right_valid),
      .right_ahead (right_ahead),
      .ent         (ent[i]),
      .valid       (valid[i]),
      .ahead       (ahead[i]),
      .ent_nxt     (nxt[i])
    );
  end

  assign head_ent     = ent[0];
  assign head_ent_nxt = nxt[0];

endmodule

[rtl/core/kway_merge_priority_queue_core.sv]
// ----------------------------------------------------------------------------
// kway_merge_priority_queue_core
// Min-priority queue for a k-way merge, built as a sorted row of cells.
//
//   channel | direction | handshake          | beat
//   in_     | input     | in_valid/in_ready   | in_beat_t (command, run, key)
//   out_    | output    | out_valid/out_ready | out_beat_t (popped, top, count)
//   cfg_    | input     | APB, pready high    | key_signed at byte address 0
//
// An accepted beat is held in op_r while the whole row updates; the row and the
// result register load at the same edge, so the result is registered in out_r
// after op_r, and beats sustain one per cycle while out_ready is high, set by the
// parallel compare in every cell.
// Reset empties the queue and clears key_signed; no clearing pass.
// A result that is not taken holds the pending beat, which holds in_ready low.
// ----------------------------------------------------------------------------
module kway_merge_priority_queue_core
  import kwmpq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_beat_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic             key_signed_r;
  logic             op_v_r;
  in_beat_t         op_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  out_beat_t        out_r;
  out_beat_t        out_nxt;

  cmd_t     cmd;
  logic     exec;
  logic     op_ok;
  status_t  status;
  row_ctl_t ctl;
  entry_t   head_ent;
  entry_t   head_ent_nxt;
  logic     reg_sel;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[CFG_ADDR_W-1:2] == REG_KEY_SIGNED;
  assign cfg_prdata = reg_sel ? {{(CFG_DATA_W-1){1'b0}}, key_signed_r} : '0;

  assign cmd      = cmd_t'(op_r.command);
  assign exec     = op_v_r && (!out_valid_r || out_ready);
  assign in_ready = !op_v_r || exec;

  always_comb begin
    status    = STATUS_OK;
    op_ok     = 1'b1;
    count_nxt = count_r;
    unique case (cmd)
      CMD_INSERT: begin
        if (count_r == CNT_FULL) begin
          status = STATUS_FULL;
          op_ok  = 1'b0;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_REPLACE: begin
        if (count_r == '0) begin
          status = STATUS_EMPTY;
          op_ok  = 1'b0;
        end
      end
      CMD_REMOVE: begin
        if (count_r == '0) begin
          status = STATUS_EMPTY;
          op_ok  = 1'b0;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
        count_nxt = '0;
      end
    endcase
  end

  always_comb begin
    ctl.en         = exec && op_ok;
    ctl.cmd        = cmd;
    ctl.key_signed = key_signed_r;
    ctl.ent.key    = op_r.key;
    ctl.ent.run    = (cmd == CMD_REPLACE) ? head_ent.run : op_r.run;
  end

  kwmpq_row u_row (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .head_ent     (head_ent),
    .head_ent_nxt (head_ent_nxt)
  );

  always_comb begin
    out_nxt              = '0;
    out_nxt.popped_valid = op_ok && (cmd == CMD_REPLACE || cmd == CMD_REMOVE);
    if (out_nxt.popped_valid) begin
      out_nxt.popped_key = head_ent.key;
      out_nxt.popped_run = head_ent.run;
    end
    out_nxt.top_valid = count_nxt != '0;
    if (out_nxt.top_valid) begin
      out_nxt.top_key = head_ent_nxt.key;
      out_nxt.top_run = head_ent_nxt.run;
    end
    out_nxt.entry_count = count_nxt;
    out_nxt.status      = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_signed_r <= 1'b0;
      op_v_r       <= 1'b0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
        key_signed_r <= cfg_pwdata[0];
      end
      if (in_valid && in_ready) begin
        op_v_r <= 1'b1;
      end else if (exec) begin
        op_v_r <= 1'b0;
      end
      if (exec) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r <= in_data;
    end
    if (exec) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/core/kwmpq_checker.sv]
// ----------------------------------------------------------------------------
// kwmpq_checker
// Port-level checks on the merge queue's result beats.
// ----------------------------------------------------------------------------
module kwmpq_checker
  import kwmpq_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_beat_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.popped_valid |-> out_data.status == STATUS_OK)
    else $error("pop flagged with error status");

  a_top_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.top_valid == (out_data.entry_count != '0)
                  && out_data.entry_count <= CNT_FULL)
    else $error("top valid disagrees with count");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.top_valid |-> out_data.top_key == '0
                                         && out_data.top_run == '0)
    else $error("empty queue shows a top entry");

  a_status_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STATUS_FULL |-> out_data.entry_count == CNT_FULL
                                                   && !out_data.popped_valid)
    else $error("full status with room left");

endmodule

bind kway_merge_priority_queue_core kwmpq_checker u_kwmpq_checker (.*);
